/* rtl/core/framed_command_receiver_core_defines.svh */
// ----------------------------------------------------------------------------
// framed_command_receiver_core_defines
// assertion macros used by the checker file of the receiver
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_CORE_DEFINES_SVH

// clocked property, switched off while reset is held
`define FCR_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked property that is also checked during reset
`define FCR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/core/fcr_pkg.sv */
// ----------------------------------------------------------------------------
// fcr_pkg
// types, constants and helpers for the framed command receiver
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

    localparam int FRAME_MAX_DEF = 10;

    localparam int IN_W    = 8;
    localparam int FIELD_W = 46;
    localparam int OUT_W   = 48;
    localparam int OUT_PAD_W = OUT_W - FIELD_W;

    localparam logic [7:0] OPEN_MARK  = 8'h24;
    localparam logic [7:0] CLOSE_MARK = 8'h23;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    // command table, byte i of a pattern sits at bits [8i+7:8i]
    localparam int NUM_CMD   = 6;
    localparam int CMD_SMON  = 0;
    localparam int CMD_SMOFF = 1;
    localparam int CMD_SIH   = 2;
    localparam int CMD_SIL   = 3;
    localparam int CMD_MD    = 4;
    localparam int CMD_TO    = 5;

    localparam logic [63:0] CMD_PAT [NUM_CMD] = '{
        64'h0000_004E_4F4D_5324,   // $SMON
        64'h0000_4646_4F4D_5324,   // $SMOFF
        64'h0000_0000_4849_5324,   // $SIH
        64'h0000_0000_4C49_5324,   // $SIL
        64'h0000_0000_0044_4D24,   // $MD
        64'h0000_0000_004F_5424    // $TO
    };
    localparam logic [2:0] CMD_LEN [NUM_CMD] = '{3'd5, 3'd6, 3'd4, 3'd4, 3'd3, 3'd3};
    // exact commands need the frame to end right after the pattern
    localparam logic CMD_EXACT [NUM_CMD] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

    localparam logic [7:0] HIGH_RST = 8'hff;
    localparam logic [9:0] DIST_RST = 10'd400;

    typedef struct packed {
        logic start;    // frame opened, '$' stored at index 0
        logic store;    // byte stored inside a frame
        logic close;    // closing mark received
    } t_dec_ctl;

    typedef struct packed {
        logic       timeout_changed;
        logic       intensity_changed;
        logic [9:0] timeout_count;
        logic [9:0] max_distance;
        logic [6:0] intensity_low;
        logic [7:0] intensity_high;
        logic       security_on;
    } t_settings;

    function automatic logic pat_ok(input logic [7:0] b, input logic [2:0] pos,
                                    input logic [63:0] pat, input logic [2:0] plen);
        return (pos >= plen) || (b == pat[{pos, 3'b000} +: 8]);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fcr_ram.sv */
// ----------------------------------------------------------------------------
// fcr_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/fcr_decode.sv */
// ----------------------------------------------------------------------------
// fcr_decode
// command matcher and settings registers, fed with each stored byte
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_decode #(
    parameter int FRAME_MAX = fcr_pkg::FRAME_MAX_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire fcr_pkg::t_dec_ctl                  i_ctl,
    input  wire logic [$clog2(FRAME_MAX+2)-1:0]     i_idx,
    input  wire logic [7:0]                         i_byte,
    output fcr_pkg::t_settings                      o_set
);

    import fcr_pkg::*;

    localparam int AW = $clog2(FRAME_MAX + 2);

    logic [NUM_CMD-1:0] r_ok, n_ok;
    logic [9:0]         r_acc4, n_acc4;
    logic               r_live4, n_live4;
    logic [9:0]         r_acc5, n_acc5;
    logic [6:0]         r_acc5s, n_acc5s;
    logic               r_live5, n_live5;
    t_settings          r_set, n_set;

    always_comb begin
        logic             lo;
        logic             digit;
        logic [3:0]       dval;
        logic [NUM_CMD-1:0] hit;

        n_ok    = r_ok;
        n_acc4  = r_acc4;
        n_live4 = r_live4;
        n_acc5  = r_acc5;
        n_acc5s = r_acc5s;
        n_live5 = r_live5;
        n_set   = r_set;

        lo    = (i_idx < AW'(8));
        digit = i_byte inside {[8'h30:8'h39]};
        dval  = i_byte[3:0];
        hit   = '0;

        if (i_ctl.start) begin
            n_ok    = '1;
            n_acc4  = '0;
            n_live4 = 1'b1;
            n_acc5  = '0;
            n_acc5s = '0;
            n_live5 = 1'b1;
        end else if (i_ctl.store) begin
            for (int c = 0; c < NUM_CMD; c++) begin
                if (lo && !pat_ok(i_byte, i_idx[2:0], CMD_PAT[c], CMD_LEN[c])) begin
                    n_ok[c] = 1'b0;
                end
            end
            // digits after the two-letter commands
            if (i_idx >= AW'(4) && i_idx <= AW'(6)) begin
                if (r_live4 && digit) begin
                    n_acc4 = 10'((r_acc4 << 3) + (r_acc4 << 1)) + 10'(dval);
                end else begin
                    n_live4 = 1'b0;
                end
            end
            // digits after the three-letter commands
            if (i_idx >= AW'(5) && i_idx <= AW'(7)) begin
                if (r_live5 && digit) begin
                    n_acc5 = 10'((r_acc5 << 3) + (r_acc5 << 1)) + 10'(dval);
                    if (i_idx <= AW'(6)) begin
                        n_acc5s = 7'((r_acc5s << 3) + (r_acc5s << 1)) + 7'(dval);
                    end
                end else begin
                    n_live5 = 1'b0;
                end
            end
        end else if (i_ctl.close) begin
            for (int c = 0; c < NUM_CMD; c++) begin
                if (CMD_EXACT[c]) begin
                    hit[c] = r_ok[c] && (i_idx == AW'(CMD_LEN[c]));
                end else begin
                    hit[c] = r_ok[c] && (i_idx >= AW'(CMD_LEN[c]));
                end
            end
            n_set.intensity_changed = 1'b0;
            n_set.timeout_changed   = 1'b0;
            if (hit[CMD_SMON]) begin
                n_set.security_on = 1'b1;
            end else if (hit[CMD_SMOFF]) begin
                n_set.security_on = 1'b0;
            end else if (hit[CMD_SIH]) begin
                n_set.intensity_high    = r_acc5[7:0];
                n_set.intensity_changed = 1'b1;
            end else if (hit[CMD_SIL]) begin
                n_set.intensity_low     = r_acc5s;
                n_set.intensity_changed = 1'b1;
            end else if (hit[CMD_MD]) begin
                n_set.max_distance = r_acc4;
            end else if (hit[CMD_TO]) begin
                n_set.timeout_count   = r_acc4;
                n_set.timeout_changed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_acc4  <= n_acc4;
        r_live4 <= n_live4;
        r_acc5  <= n_acc5;
        r_acc5s <= n_acc5s;
        r_live5 <= n_live5;
        if (!i_rst_n) begin
            r_set.security_on       <= 1'b0;
            r_set.intensity_high    <= HIGH_RST;
            r_set.intensity_low     <= '0;
            r_set.max_distance      <= DIST_RST;
            r_set.timeout_count     <= '0;
            r_set.intensity_changed <= 1'b0;
            r_set.timeout_changed   <= 1'b0;
        end else begin
            r_set <= n_set;
        end
    end

    assign o_set = r_set;

endmodule

`default_nettype wire

/* rtl/core/framed_command_receiver_core.sv */
// ----------------------------------------------------------------------------
// framed_command_receiver_core
// collects '$'...'#' frames into a small ram, echoes them and decodes commands
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the block collects a frame;
// each in-frame byte that fits is written into the frame ram in the cycle
// it is accepted. A closing '#' starts the echo: the stored frame and the
// '#' are read back through the ram's single registered read port, one
// item per cycle while the sink is ready, followed by a NUL item with tlast
// set. The run holds frame length + 2 items, at most FRAME_MAX + 2, and the
// first item passes the ram's read register and then the output register.
// No byte is accepted from the '#' until the NUL item has been taken; the
// settings carried by the items are those after the frame was decoded.
`default_nettype none

module framed_command_receiver_core #(
    parameter int FRAME_MAX = fcr_pkg::FRAME_MAX_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [fcr_pkg::IN_W-1:0]   s_axis_tdata,   // rx_byte [7:0]
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // echo_char [7:0], security_on [8], intensity_high [16:9],
    // intensity_low [23:17], max_distance [33:24], timeout_count [43:34],
    // intensity_changed [44], timeout_changed [45], zero [47:46]
    output logic      [fcr_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast    // last
);

    import fcr_pkg::*;

    localparam int DEPTH = FRAME_MAX + 2;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic {
        ST_RECV,
        ST_ECHO
    } t_state;

    t_state         r_state, n_state;
    logic           r_in_frame, n_in_frame;
    logic [AW-1:0]  r_len, n_len;
    logic [AW-1:0]  r_end, n_end;
    logic [AW-1:0]  r_k, n_k;
    logic           r_issued, n_issued;
    logic           r_pend, n_pend;
    logic           r_pend_nul, n_pend_nul;
    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_ochar, n_ochar;
    logic           r_olast, n_olast;

    logic           in_acc;
    logic           adv;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;
    t_dec_ctl       dec_ctl;
    t_settings      set;

    assign s_axis_tready = (r_state == ST_RECV);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign adv           = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_len      = r_len;
        n_end      = r_end;
        n_k        = r_k;
        n_issued   = r_issued;
        n_pend     = r_pend;
        n_pend_nul = r_pend_nul;
        n_ovalid   = r_ovalid;
        n_ochar    = r_ochar;
        n_olast    = r_olast;
        ram_we     = 1'b0;
        ram_waddr  = r_len;
        ram_re     = 1'b0;
        ram_raddr  = r_k;
        dec_ctl    = '0;

        case (r_state)
            ST_RECV: begin
                if (in_acc) begin
                    if (!r_in_frame || s_axis_tdata != CLOSE_MARK) begin
                        if (r_in_frame && r_len >= AW'(FRAME_MAX)) begin
                            // overlong frame, the byte goes with it
                            n_in_frame = 1'b0;
                            n_len      = '0;
                        end else if (s_axis_tdata == OPEN_MARK) begin
                            ram_we        = 1'b1;
                            ram_waddr     = '0;
                            n_len         = AW'(1);
                            n_in_frame    = 1'b1;
                            dec_ctl.start = 1'b1;
                        end else if (r_in_frame) begin
                            ram_we        = 1'b1;
                            n_len         = r_len + AW'(1);
                            dec_ctl.store = 1'b1;
                        end
                    end else begin
                        ram_we        = 1'b1;
                        dec_ctl.close = 1'b1;
                        n_end         = r_len;
                        n_in_frame    = 1'b0;
                        n_len         = '0;
                        n_k           = '0;
                        n_issued      = 1'b0;
                        n_pend        = 1'b0;
                        n_pend_nul    = 1'b0;
                        n_ovalid      = 1'b0;
                        n_state       = ST_ECHO;
                    end
                end
            end
            ST_ECHO: begin
                if (adv) begin
                    n_ovalid = r_pend;
                    n_ochar  = r_pend_nul ? NUL_CHAR : ram_rdata;
                    n_olast  = r_pend_nul;
                    n_pend   = !r_issued;
                    if (!r_issued) begin
                        // stored bytes up to the '#', then the NUL
                        if (r_k == AW'(r_end + AW'(1))) begin
                            n_pend_nul = 1'b1;
                            n_issued   = 1'b1;
                        end else begin
                            ram_re     = 1'b1;
                            n_pend_nul = 1'b0;
                        end
                        n_k = r_k + AW'(1);
                    end
                end
                if (r_ovalid && m_axis_tready && r_olast) begin
                    n_state = ST_RECV;
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_end      <= n_end;
        r_k        <= n_k;
        r_pend_nul <= n_pend_nul;
        r_ochar    <= n_ochar;
        r_olast    <= n_olast;
        if (!i_rst_n) begin
            r_state    <= ST_RECV;
            r_in_frame <= 1'b0;
            r_len      <= '0;
            r_issued   <= 1'b0;
            r_pend     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_len      <= n_len;
            r_issued   <= n_issued;
            r_pend     <= n_pend;
            r_ovalid   <= n_ovalid;
        end
    end

    fcr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fcr_decode #(
        .FRAME_MAX (FRAME_MAX)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dec_ctl),
        .i_idx   (r_len),
        .i_byte  (s_axis_tdata),
        .o_set   (set)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {
        {OUT_PAD_W{1'b0}},
        set.timeout_changed,
        set.intensity_changed,
        set.timeout_count,
        set.max_distance,
        set.intensity_low,
        set.intensity_high,
        set.security_on,
        r_ochar
    };

endmodule

`default_nettype wire

/* rtl/core/fcr_checker.sv */
// ----------------------------------------------------------------------------
// fcr_checker
// port-level checks for the framed command receiver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_command_receiver_core_defines.svh"

module fcr_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic [fcr_pkg::IN_W-1:0]  s_axis_tdata,   // rx_byte [7:0]
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [fcr_pkg::OUT_W-1:0] m_axis_tdata,   // echo_char [7:0] first
    input wire logic                      m_axis_tlast
);

    import fcr_pkg::*;

    // no byte is taken while an echo item waits
    `FCR_ASSERT_CLK(a_no_rx_during_echo, m_axis_tvalid |-> !s_axis_tready, "rx ready during echo")

    // every run closes with a NUL item
    `FCR_ASSERT_CLK(a_last_is_nul, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == NUL_CHAR), "last item not NUL")

    // receiver is back right after the run ends
    `FCR_ASSERT_CLK(a_ready_after_run, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready, "not ready after run")

    // a stalled item holds
    `FCR_ASSERT_CLK(a_hold_on_stall, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled item changed")

    // reset empties the output
    `FCR_ASSERT_RST(a_reset_clears, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind framed_command_receiver_core fcr_checker u_fcr_checker (.*);

`default_nettype wire
